// ===== src/bbi_pkg.sv =====
// shared types and constants for the bicubic b-spline interpolator
`default_nettype none
package bbi_pkg;
	localparam int FRAC_BITS  = 16;
	localparam int PIXEL_BITS = 16;
	localparam int AXIS_BITS  = 10;
	localparam int COORD_BITS = AXIS_BITS + FRAC_BITS;
	localparam int CFG_BITS   = AXIS_BITS + 1;
	localparam int ADDR_BITS  = 2 * AXIS_BITS;
	localparam int W_BITS     = 16;
	localparam int ACC_BITS   = PIXEL_BITS + 2 * W_BITS;
	localparam logic [CFG_BITS-1:0] MAX_ROWS = CFG_BITS'(1024);
	localparam logic [CFG_BITS-1:0] MAX_COLS = CFG_BITS'(1024);
	localparam logic [21:0] RECIP6 = 22'd2796203;
	localparam int RECIP_SHIFT = 24;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_INTERP = 1'b1;
	localparam logic REG_ROWS  = 1'b0;
	localparam logic REG_COLS  = 1'b1;

	typedef struct packed {
		logic                  op;
		logic [AXIS_BITS-1:0]  pixel_row;
		logic [AXIS_BITS-1:0]  pixel_col;
		logic [PIXEL_BITS-1:0] pixel_value;
		logic [COORD_BITS-1:0] coord_row;
		logic [COORD_BITS-1:0] coord_col;
	} req_word_t;

	typedef struct packed {
		logic [31:0] interp_value;
		logic        outside;
	} rsp_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WGT,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       mem_wr;
		logic       issue;
		logic [3:0] tap;
		logic       res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic outside;
	} dp_sts_t;
endpackage
`default_nettype wire

// ===== src/bbi_if.sv =====
// valid/ready channel interfaces for request and response words
`default_nettype none
interface bbi_req_if;
	logic               valid;
	logic               ready;
	bbi_pkg::req_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface bbi_rsp_if;
	logic               valid;
	logic               ready;
	bbi_pkg::rsp_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

// ===== src/bbi_ctrl.sv =====
// controller state machine sequencing weight setup, taps and result
`default_nettype none
module bbi_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_op,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	input  wire bbi_pkg::dp_sts_t  sts,
	output bbi_pkg::dp_cmd_t       cmd
);
	import bbi_pkg::*;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.res_load)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.tap  = cnt_q;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cnt_d     = '0;
				if (req_valid && req_op == OP_WRITE)
					cmd.mem_wr = 1'b1;
				if (req_valid && req_op == OP_INTERP) begin
					cmd.capture = 1'b1;
					state_d     = sts.outside ? ST_DONE : ST_WGT;
				end
			end
			ST_WGT: begin
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd3) begin
					cnt_d   = '0;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				cnt_d     = cnt_q + 4'd1;
				if (cnt_q == 4'd15)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd3) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign rsp_valid = out_valid_q;
endmodule
`default_nettype wire

// ===== src/bbi_dp.sv =====
// datapath: image memory, b-spline weights, multiply-accumulate, result
`default_nettype none
module bbi_dp (
	input  wire logic                              clk,
	input  wire bbi_pkg::req_word_t                req_word,
	input  wire logic [bbi_pkg::CFG_BITS-1:0]      cfg_rows,
	input  wire logic [bbi_pkg::CFG_BITS-1:0]      cfg_cols,
	input  wire bbi_pkg::dp_cmd_t                  cmd,
	output bbi_pkg::dp_sts_t                       sts,
	output bbi_pkg::rsp_word_t                     rsp_word
);
	import bbi_pkg::*;

	logic [PIXEL_BITS-1:0] image_mem [2**ADDR_BITS];

	logic [AXIS_BITS-1:0] ir, ic;
	logic [CFG_BITS-1:0]  lim_r, lim_c;
	logic [AXIS_BITS-1:0] ir_q, ic_q;
	logic [FRAC_BITS-1:0] frac_q [2];
	logic                 outside_q;

	logic [31:0] f2_s1 [2];
	logic [32:0] g2_s1 [2];
	logic [16:0] g_s1 [2];
	logic [47:0] f3_s2 [2];
	logic [48:0] g3_s2 [2];
	logic [31:0] f2_s2 [2];
	logic [20:0] x_s3 [2][4];
	logic [W_BITS-1:0] w_s4 [2][4];

	logic [AXIS_BITS-1:0]  rd_row, rd_col;
	logic [ADDR_BITS-1:0]  mem_addr;
	logic [PIXEL_BITS-1:0] rd_s1;
	logic [3:0]            tap_s1, tap_s2;
	logic                  v_s1, v_s2, v_s3;
	logic [31:0]           p1_s2;
	logic [ACC_BITS-1:0]   p2_s3;
	logic [ACC_BITS-1:0]   acc_q;

	assign ir    = req_word.coord_row[COORD_BITS-1:FRAC_BITS];
	assign ic    = req_word.coord_col[COORD_BITS-1:FRAC_BITS];
	assign lim_r = (cfg_rows < MAX_ROWS) ? cfg_rows : MAX_ROWS;
	assign lim_c = (cfg_cols < MAX_COLS) ? cfg_cols : MAX_COLS;
	assign sts.outside = (ir < AXIS_BITS'(2)) || (CFG_BITS'(ir) + CFG_BITS'(1) >= lim_r)
		|| (ic < AXIS_BITS'(2)) || (CFG_BITS'(ic) + CFG_BITS'(1) >= lim_c);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ir_q      <= ir;
			ic_q      <= ic;
			frac_q[0] <= req_word.coord_row[FRAC_BITS-1:0];
			frac_q[1] <= req_word.coord_col[FRAC_BITS-1:0];
			outside_q <= sts.outside;
		end
	end

	// weight pipeline, one lane per axis
	always_ff @(posedge clk) begin
		logic [16:0] g;
		logic [52:0] n1, n2;
		for (int k = 0; k < 2; k++) begin
			g        = 17'h10000 - 17'(frac_q[k]);
			g_s1[k]  <= g;
			f2_s1[k] <= 32'(frac_q[k]) * 32'(frac_q[k]);
			g2_s1[k] <= 33'(g) * 33'(g);
			f2_s2[k] <= f2_s1[k];
			f3_s2[k] <= 48'(f2_s1[k]) * 48'(frac_q[k]);
			g3_s2[k] <= 49'(g2_s1[k]) * 49'(g_s1[k]);
			n1 = 53'(f3_s2[k]) * 53'd3 + (53'd1 << 50)
				- (53'(f2_s2[k]) << 18) - (53'(f2_s2[k]) << 17);
			n2 = (53'(f2_s2[k]) << 17) + (53'(f2_s2[k]) << 16)
				+ (53'(frac_q[k]) << 33) + (53'(frac_q[k]) << 32)
				+ (53'd1 << 48) - 53'(f3_s2[k]) * 53'd3;
			x_s3[k][0] <= 21'(g3_s2[k][48:32]);
			x_s3[k][1] <= n1[52:32];
			x_s3[k][2] <= n2[52:32];
			x_s3[k][3] <= 21'(f3_s2[k][47:32]);
			for (int j = 0; j < 4; j++)
				w_s4[k][j] <= W_BITS'((43'(x_s3[k][j]) * 43'(RECIP6)) >> RECIP_SHIFT);
		end
	end

	assign rd_row   = ir_q - AXIS_BITS'(2) + AXIS_BITS'(cmd.tap[3:2]);
	assign rd_col   = ic_q - AXIS_BITS'(2) + AXIS_BITS'(cmd.tap[1:0]);
	assign mem_addr = cmd.mem_wr ? {req_word.pixel_row, req_word.pixel_col} : {rd_row, rd_col};

	always_ff @(posedge clk) begin
		if (cmd.mem_wr)
			image_mem[mem_addr] <= req_word.pixel_value;
		rd_s1 <= image_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		v_s1   <= cmd.issue;
		tap_s1 <= cmd.tap;
		v_s2   <= v_s1;
		tap_s2 <= tap_s1;
		p1_s2  <= 32'(rd_s1) * 32'(w_s4[0][tap_s1[3:2]]);
		v_s3   <= v_s2;
		p2_s3  <= ACC_BITS'(p1_s2) * ACC_BITS'(w_s4[1][tap_s2[1:0]]);
		if (cmd.capture)
			acc_q <= '0;
		else if (v_s3)
			acc_q <= acc_q + p2_s3;
		if (cmd.res_load) begin
			rsp_word.interp_value <= outside_q ? 32'd0 : acc_q[47:16];
			rsp_word.outside      <= outside_q;
		end
	end
endmodule
`default_nettype wire

// ===== src/bicubic_bspline_interp_core.sv =====
// Top level of the cubic b-spline image interpolator with APB register port.
// Pixel write: no response word.
// Query: weight setup, 16 reads of the single-port image memory, pipeline drain, then the
// result load; the load waits while an earlier response is still valid and not taken.
// Out-of-image queries go straight to the result load. Reset: registers to 1024, memory undefined.
`default_nettype none
module bicubic_bspline_interp_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	bbi_req_if.sink          req,
	bbi_rsp_if.source        rsp
);
	import bbi_pkg::*;

	logic [CFG_BITS-1:0] rows_q, cols_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_q) : 32'(rows_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_BITS'(1024);
			cols_q <= CFG_BITS'(1024);
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_ROWS)
				rows_q <= pwdata[CFG_BITS-1:0];
			else
				cols_q <= pwdata[CFG_BITS-1:0];
		end
	end

	bbi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.word.op),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bbi_dp u_dp (
		.clk      (clk),
		.req_word (req.word),
		.cfg_rows (rows_q),
		.cfg_cols (cols_q),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_word (rsp.word)
	);

	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !req.ready) else $error("tap issued while accepting");
	a_wr_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr |-> !cmd.issue) else $error("memory write during tap read");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> rsp.valid) else $error("result load lost");
endmodule
`default_nettype wire
